// File: sv/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg
// shared types and constants of the session frame parser
// ----------------------------------------------------------------------------
package sfp_pkg;

    localparam int POSITION_WIDTH_DEF = 33;
    localparam int QUEUE_DEPTH_DEF    = 4;

    localparam int HEADER_BYTES = 24;
    localparam int LEG_BYTES    = 28;
    localparam int NUM_WORDS    = 7;
    localparam int LEG_REL_W    = 5;
    localparam int TABLE_END_W  = 21;
    localparam int NEED_W       = 33;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int MAX_LEGS_W = 16;
    localparam logic [MAX_LEGS_W-1:0] MAX_LEGS_RESET = 16'd64;

    localparam logic REG_MAGIC    = 1'b0;
    localparam logic REG_MAX_LEGS = 1'b1;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 232;
    localparam int WORD_G_LSB = 192;
    localparam int STATUS_LSB = 224;

    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_LEG,
        KIND_REF,
        KIND_END
    } sfp_kind_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_TRUNC,
        ST_BAD_MAGIC,
        ST_BOUNDS
    } sfp_status_t;

    typedef struct packed {
        logic [31:0]           session_magic;
        logic [MAX_LEGS_W-1:0] max_legs;
    } sfp_cfg_t;

    typedef struct packed {
        logic                         rec_valid;
        sfp_kind_t                    rec_kind;
        logic [NUM_WORDS-1:0][31:0]   words;
        logic                         end_valid;
        sfp_status_t                  status;
        logic [NEED_W-1:0]            consumed;
    } sfp_entry_t;

endpackage

// File: sv/sfp_csr.sv
// ----------------------------------------------------------------------------
// sfp_csr
// apb register file: session magic and leg count limit
// ----------------------------------------------------------------------------
module sfp_csr (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [sfp_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [sfp_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready,
    output sfp_pkg::sfp_cfg_t               cfg
);
    import sfp_pkg::*;

    logic [31:0]           magic_reg;
    logic [MAX_LEGS_W-1:0] max_legs_reg;
    logic                  wr_en;
    logic                  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[CFG_ADDR_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            magic_reg    <= '0;
            max_legs_reg <= MAX_LEGS_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_MAGIC:    magic_reg    <= pwdata[31:0];
                REG_MAX_LEGS: max_legs_reg <= pwdata[MAX_LEGS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_MAGIC:    prdata = magic_reg;
            REG_MAX_LEGS: prdata = {{(CFG_DATA_W-MAX_LEGS_W){1'b0}}, max_legs_reg};
            default:      prdata = '0;
        endcase
    end

    assign cfg.session_magic = magic_reg;
    assign cfg.max_legs      = max_legs_reg;

endmodule

// File: sv/sfp_front.sv
// ----------------------------------------------------------------------------
// sfp_front
// byte classifier: header, leg table and reference regions, end status
// ----------------------------------------------------------------------------
module sfp_front #(
    parameter int POSITION_WIDTH = sfp_pkg::POSITION_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sfp_pkg::sfp_cfg_t              cfg,
    input  logic                           accept,
    input  logic [sfp_pkg::IN_DATA_W-1:0]  frame_byte,
    input  logic                           final_byte,
    output logic                           push,
    output sfp_pkg::sfp_entry_t            entry
);
    import sfp_pkg::*;

    localparam int PW = POSITION_WIDTH;
    localparam int CW = (PW > NEED_W) ? PW : NEED_W;
    localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

    logic [PW-1:0]               pos_reg, pos_next, pos_inc;
    logic [31:0]                 wa_reg, wa_next, wa_shift;
    logic [NUM_WORDS-1:0][31:0]  store_reg, store_next;
    sfp_status_t                 err_reg, err_next;
    logic [TABLE_END_W-1:0]      table_end_reg, table_end_next, te_calc;
    logic [NEED_W-1:0]           need_reg, need_next, need_fin;
    logic [31:0]                 ref_max_reg, ref_max_next;
    logic [LEG_REL_W-1:0]        leg_rel_reg, leg_rel_next;
    logic [31:0]                 sum_reg, cand_max_reg;
    logic [NEED_W-1:0]           cand_need_reg;

    logic                        active, in_hdr, in_legs, in_refs;
    logic                        hdr_last, leg_last, leg_done;
    logic [15:0]                 legs_field;

    assign active   = accept && (pos_reg != POS_MAX) && (err_reg == ST_OK);
    assign in_hdr   = CW'(pos_reg) < CW'(HEADER_BYTES);
    assign in_legs  = CW'(pos_reg) < CW'(table_end_reg);
    assign in_refs  = CW'(pos_reg) < CW'(need_reg);
    assign wa_shift = {frame_byte, wa_reg[31:8]};
    assign hdr_last = pos_reg == PW'(HEADER_BYTES - 1);
    assign leg_last = leg_rel_reg == LEG_REL_W'(LEG_BYTES - 1);
    assign leg_done = active && !in_hdr && in_legs && leg_last;
    assign legs_field = store_reg[1][31:16];
    assign te_calc  = TABLE_END_W'({legs_field, 5'b0}) - TABLE_END_W'({legs_field, 2'b0})
                    + TABLE_END_W'(HEADER_BYTES);
    assign pos_inc  = (pos_reg == POS_MAX) ? pos_reg : pos_reg + PW'(1);
    assign need_fin = leg_done ? cand_need_reg : need_reg;

    always_comb begin
        pos_next       = pos_reg;
        wa_next        = wa_reg;
        store_next     = store_reg;
        err_next       = err_reg;
        table_end_next = table_end_reg;
        need_next      = need_reg;
        ref_max_next   = ref_max_reg;
        leg_rel_next   = leg_rel_reg;
        entry          = '0;

        if (active) begin
            if (in_hdr) begin
                wa_next = wa_shift;
                if (pos_reg[1:0] == 2'b11) begin
                    store_next[pos_reg[4:2]] = wa_shift;
                end
                if (hdr_last) begin
                    if (store_reg[0] != cfg.session_magic) begin
                        err_next = ST_BAD_MAGIC;
                    end else if (legs_field > cfg.max_legs) begin
                        err_next = ST_BOUNDS;
                    end else begin
                        table_end_next  = te_calc;
                        need_next       = NEED_W'(te_calc);
                        entry.rec_valid = 1'b1;
                        entry.rec_kind  = KIND_HEADER;
                        entry.words[0]  = {16'b0, store_reg[1][15:0]};
                        entry.words[1]  = {16'b0, legs_field};
                        entry.words[2]  = store_reg[2];
                        entry.words[3]  = store_reg[3];
                        entry.words[4]  = store_reg[4];
                        entry.words[5]  = wa_shift;
                    end
                end
            end else if (in_legs) begin
                wa_next      = wa_shift;
                leg_rel_next = leg_last ? '0 : leg_rel_reg + LEG_REL_W'(1);
                if (leg_rel_reg[1:0] == 2'b11) begin
                    store_next[leg_rel_reg[4:2]] = wa_shift;
                end
                if (leg_last) begin
                    ref_max_next    = cand_max_reg;
                    need_next       = cand_need_reg;
                    entry.rec_valid = 1'b1;
                    entry.rec_kind  = KIND_LEG;
                    entry.words[0]  = store_reg[0];
                    entry.words[1]  = store_reg[1];
                    entry.words[2]  = store_reg[2];
                    entry.words[3]  = store_reg[3];
                    entry.words[4]  = store_reg[4];
                    entry.words[5]  = store_reg[5];
                    entry.words[6]  = wa_shift;
                end
            end else if (in_refs) begin
                entry.rec_valid = 1'b1;
                entry.rec_kind  = KIND_REF;
                entry.words[0]  = {24'b0, frame_byte};
            end
        end

        if (accept) begin
            pos_next = pos_inc;
        end

        // end of frame: status record, then back to the start of a frame
        if (accept && final_byte) begin
            entry.end_valid = 1'b1;
            if (CW'(pos_inc) < CW'(HEADER_BYTES)) begin
                entry.status = ST_TRUNC;
            end else if (err_next != ST_OK) begin
                entry.status = err_next;
            end else if (CW'(pos_inc) < CW'(need_fin)) begin
                entry.status = ST_BOUNDS;
            end else begin
                entry.status   = ST_OK;
                entry.consumed = need_fin;
            end
            pos_next       = '0;
            err_next       = ST_OK;
            table_end_next = TABLE_END_W'(HEADER_BYTES);
            need_next      = NEED_W'(HEADER_BYTES);
            ref_max_next   = '0;
            leg_rel_next   = '0;
        end

        push = entry.rec_valid || entry.end_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            err_reg       <= ST_OK;
            table_end_reg <= TABLE_END_W'(HEADER_BYTES);
            need_reg      <= NEED_W'(HEADER_BYTES);
            ref_max_reg   <= '0;
            leg_rel_reg   <= '0;
        end else begin
            pos_reg       <= pos_next;
            err_reg       <= err_next;
            table_end_reg <= table_end_next;
            need_reg      <= need_next;
            ref_max_reg   <= ref_max_next;
            leg_rel_reg   <= leg_rel_next;
        end
    end

    // reference end candidate, settled in the last bytes of each leg
    always_ff @(posedge aclk) begin
        wa_reg        <= wa_next;
        store_reg     <= store_next;
        sum_reg       <= store_reg[4] + store_reg[5];
        cand_max_reg  <= ((store_reg[5] != '0) && (sum_reg > ref_max_reg)) ? sum_reg
                                                                           : ref_max_reg;
        cand_need_reg <= NEED_W'(table_end_reg) + NEED_W'(cand_max_reg);
    end

endmodule

// File: sv/sfp_queue.sv
// ----------------------------------------------------------------------------
// sfp_queue
// short record queue between the classifier and the output stage
// ----------------------------------------------------------------------------
module sfp_queue #(
    parameter int DEPTH = sfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  sfp_pkg::sfp_entry_t  entry_in,
    output logic                 ready,
    input  logic                 pop,
    output sfp_pkg::sfp_entry_t  head,
    output logic                 empty
);
    import sfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    sfp_entry_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_pop;

    assign ready  = count_reg != CNT_W'(DEPTH);
    assign empty  = count_reg == '0;
    assign do_pop = pop && !empty;
    assign head   = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= entry_in;
        end
    end

endmodule

// File: sv/sfp_back.sv
// ----------------------------------------------------------------------------
// sfp_back
// output stage: expands queue entries into record transfers
// ----------------------------------------------------------------------------
module sfp_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  sfp_pkg::sfp_entry_t             head,
    input  logic                            empty,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sfp_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);
    import sfp_pkg::*;

    logic                   m_valid_reg, m_valid_next;
    sfp_kind_t              m_kind_reg, m_kind_next;
    logic [OUT_DATA_W-1:0]  m_data_reg, m_data_next;
    logic                   m_last_reg, m_last_next;
    logic                   pend_reg, pend_next;
    sfp_status_t            pend_status_reg, pend_status_next;
    logic [NEED_W-1:0]      pend_consumed_reg, pend_consumed_next;
    logic                   load;

    function automatic logic [OUT_DATA_W-1:0] end_data(sfp_status_t st,
                                                       logic [NEED_W-1:0] consumed);
        logic [OUT_DATA_W-1:0] d;
        d = '0;
        d[31:0]             = consumed[31:0];
        d[WORD_G_LSB]       = consumed[NEED_W-1];
        d[STATUS_LSB +: 2]  = st;
        return d;
    endfunction

    assign load = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next       = m_valid_reg;
        m_kind_next        = m_kind_reg;
        m_data_next        = m_data_reg;
        m_last_next        = m_last_reg;
        pend_next          = pend_reg;
        pend_status_next   = pend_status_reg;
        pend_consumed_next = pend_consumed_reg;
        pop                = 1'b0;

        if (load) begin
            if (pend_reg) begin
                m_valid_next = 1'b1;
                m_kind_next  = KIND_END;
                m_data_next  = end_data(pend_status_reg, pend_consumed_reg);
                m_last_next  = 1'b1;
                pend_next    = 1'b0;
            end else if (!empty) begin
                pop          = 1'b1;
                m_valid_next = 1'b1;
                if (head.rec_valid) begin
                    m_kind_next        = head.rec_kind;
                    m_data_next        = OUT_DATA_W'(head.words);
                    m_last_next        = 1'b0;
                    pend_next          = head.end_valid;
                    pend_status_next   = head.status;
                    pend_consumed_next = head.consumed;
                end else begin
                    m_kind_next = KIND_END;
                    m_data_next = end_data(head.status, head.consumed);
                    m_last_next = 1'b1;
                end
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_kind_reg        <= m_kind_next;
        m_data_reg        <= m_data_next;
        m_last_reg        <= m_last_next;
        pend_status_reg   <= pend_status_next;
        pend_consumed_reg <= pend_consumed_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

// File: sv/session_frame_parser.sv
// ----------------------------------------------------------------------------
// session_frame_parser
// streaming parser of session frames: header, leg table, reference bytes
// ----------------------------------------------------------------------------
// usage:
//   s_ channel: one frame byte per transfer, s_tlast on the last byte of the
//   frame buffer. m_ channel: one record per transfer, kind in m_tuser,
//   m_tlast on the end status record that closes every frame.
//   apb port: session magic at 0x0, leg count limit at 0x4.
// timing:
//   a byte is classified in the cycle of its transfer; its record is registered
//   in the record queue and then in the output register before it shows on m_.
//   one byte per cycle is taken while the queue has room; a final byte that
//   also completes a record gives two output transfers, which the output stage
//   sends one after the other. the 4-entry record queue absorbs that. the leg
//   count multiply is a shift and subtract, and the reference end update is
//   spread over the last bytes of each leg, so nothing limits the byte rate.
// reset:
//   frame state returns to the start of a frame, magic to 0, limit to 64.
// stalls:
//   when m_tready is low the output register holds; once the queue fills,
//   s_tready drops until the receiver takes records again.
// ----------------------------------------------------------------------------
module session_frame_parser #(
    parameter int POSITION_WIDTH = sfp_pkg::POSITION_WIDTH_DEF,
    parameter int QUEUE_DEPTH    = sfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sfp_pkg::IN_DATA_W-1:0]   s_tdata,   // frame_byte
    input  logic                            s_tlast,   // final_byte
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // word_a, word_b, word_c, word_d, word_e, word_f, word_g, status, zero pad
    output logic [sfp_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [1:0]                      m_tuser,   // record_kind
    output logic                            m_tlast,   // run_end
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sfp_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [sfp_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [sfp_pkg::CFG_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import sfp_pkg::*;

    sfp_cfg_t    cfg;
    sfp_entry_t  push_entry, head;
    logic        accept, push, pop, empty, q_ready;

    assign s_tready = q_ready;
    assign accept   = s_tvalid & q_ready;

    sfp_csr u_csr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sfp_front #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .accept     (accept),
        .frame_byte (s_tdata),
        .final_byte (s_tlast),
        .push       (push),
        .entry      (push_entry)
    );

    sfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .entry_in (push_entry),
        .ready    (q_ready),
        .pop      (pop),
        .head     (head),
        .empty    (empty)
    );

    sfp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// File: sv/sfp_checker.sv
// ----------------------------------------------------------------------------
// sfp_checker
// port level checks of the session frame parser output channel
// ----------------------------------------------------------------------------
module sfp_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [sfp_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [1:0]                      m_tuser,
    input logic                            m_tlast
);
    import sfp_pkg::*;

    // no record right after reset
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("record valid after reset");

    // stalled transfer holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                   && $stable(m_tlast))
        else $error("stalled record changed");

    // tlast marks exactly the end status records
    a_last_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser == KIND_END)))
        else $error("tlast and end record disagree");

    // status only on end records
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != KIND_END) |-> m_tdata[STATUS_LSB +: 2] == ST_OK)
        else $error("status set on a non-end record");

    // reference records carry a single byte
    a_ref_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_REF) |-> m_tdata[OUT_DATA_W-1:8] == '0)
        else $error("reference record wider than a byte");

endmodule

bind session_frame_parser sfp_checker u_sfp_checker (.*);
